/* src/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Implication checked also across reset.
`define ASSERT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error(msg);

`endif

/* src/psfa_pkg.sv */
package psfa_pkg;

  localparam logic [1:0] OP_ANALYZE = 2'd0;
  localparam logic [1:0] OP_BEGIN   = 2'd1;
  localparam logic [1:0] OP_REPORT  = 2'd2;
  localparam logic [1:0] OP_NONE    = 2'd3;

  localparam int unsigned NUM_REGS = 16;

  localparam logic [31:0] EXT_MASK    = 32'he0000000;
  localparam logic [31:0] PUSHM_MASK  = 32'hf00f0000;
  localparam logic [31:0] PUSHM_MATCH = 32'hd0010000;
  localparam logic [31:0] STM_MASK    = 32'hffff0000;
  localparam logic [31:0] STM_MATCH   = 32'hebcd0000;
  localparam logic [31:0] PUSH_MASK   = 32'hfff00000;
  localparam logic [31:0] PUSH_MATCH  = 32'h1aa00000;
  localparam logic [31:0] FP_MASK     = 32'hffff0000;
  localparam logic [31:0] FP_MATCH    = 32'h1a970000;
  localparam logic [31:0] SUB8_MASK   = 32'hf00f0000;
  localparam logic [31:0] SUB8_MATCH  = 32'h200d0000;
  localparam logic [31:0] SUB21_MASK  = 32'he1ef0000;
  localparam logic [31:0] SUB21_MATCH = 32'he02d0000;

  typedef enum logic [1:0] {
    KIND_UNKNOWN,
    KIND_SAVE,
    KIND_FRAME,
    KIND_ADJUST
  } kind_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] instruction;
    logic [31:0] start_address;
    logic [31:0] limit_address;
  } item_t;

  typedef struct packed {
    logic               recognized;
    logic               stopped;
    logic [31:0]        next_address;
    logic signed [31:0] stack_offset;
    logic               uses_frame_pointer;
    logic signed [31:0] frame_base_offset;
    logic [3:0]         reg_index;
    logic               reg_saved;
    logic signed [31:0] reg_offset;
    logic               last;
  } result_t;

  typedef struct packed {
    logic [1:0]       op;
    kind_t            kind;
    logic             ext;
    logic [15:0]      mask;
    logic [15:0][6:0] prefix;
    logic [31:0]      delta;
    logic [31:0]      start_address;
    logic [31:0]      limit_address;
  } entry_t;

endpackage

/* src/psfa_front.sv */
module psfa_front import psfa_pkg::*; (
  input  logic   item_valid,
  output logic   item_ready,
  input  item_t  item,
  input  logic   full,
  output logic   push,
  output entry_t entry
);

  logic        ext;
  logic [31:0] w;
  logic [15:0] mask;
  logic [31:0] imm;
  kind_t       kind;

  assign ext        = (item.instruction & EXT_MASK) == EXT_MASK;
  assign w          = ext ? item.instruction : {item.instruction[31:16], 16'h0000};
  assign item_ready = !full;
  assign push       = item_valid && !full && (item.opcode != OP_NONE);

  always_comb begin
    mask = '0;
    imm  = '0;
    kind = KIND_UNKNOWN;
    if ((w & PUSHM_MASK) == PUSHM_MATCH) begin
      kind       = KIND_SAVE;
      mask[3:0]  = {4{w[20]}};
      mask[7:4]  = {4{w[21]}};
      mask[9:8]  = {2{w[22]}};
      mask[10]   = w[23];
      mask[11]   = w[24];
      mask[12]   = w[25];
      mask[14]   = w[26];
      mask[15]   = w[27];
    end else if ((w & STM_MASK) == STM_MATCH) begin
      kind = KIND_SAVE;
      mask = w[15:0];
    end else if ((w & PUSH_MASK) == PUSH_MATCH) begin
      kind = KIND_SAVE;
      mask = 16'h0001 << w[19:16];
    end else if ((w & FP_MASK) == FP_MATCH) begin
      kind = KIND_FRAME;
    end else if ((w & SUB8_MASK) == SUB8_MATCH) begin
      kind = KIND_ADJUST;
      imm  = {{24{w[27]}}, w[27:20]};
    end else if ((w & SUB21_MASK) == SUB21_MATCH) begin
      kind = KIND_ADJUST;
      imm  = {{11{w[28]}}, w[28:25], w[20], w[15:0]};
    end
  end

  always_comb begin
    int cnt;
    int tot;
    entry.op            = item.opcode;
    entry.kind          = kind;
    entry.ext           = ext;
    entry.mask          = mask;
    entry.start_address = item.start_address;
    entry.limit_address = item.limit_address;
    for (int r = 0; r < NUM_REGS; r++) begin
      cnt = $countones(mask & ((16'h0001 << r) - 16'h0001));
      entry.prefix[r] = {cnt[4:0], 2'b00};
    end
    tot = $countones(mask);
    if (kind == KIND_ADJUST) begin
      entry.delta = 32'd0 - imm;
    end else begin
      entry.delta = {25'd0, tot[4:0], 2'b00};
    end
  end

endmodule

/* src/psfa_queue.sv */
module psfa_queue import psfa_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             slots [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign full       = count == CNT_W'(DEPTH);
  assign head_valid = count != '0;
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

/* src/psfa_back.sv */
module psfa_back import psfa_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    head_valid,
  input  entry_t  head,
  output logic    pop,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  logic [31:0] save_off      [NUM_REGS];
  logic [31:0] save_off_next [NUM_REGS];
  logic [15:0] save_vld, save_vld_next;
  logic [31:0] running, running_next;
  logic        fp_used, fp_used_next;
  logic [31:0] base, base_next;
  logic [31:0] scan_addr, scan_addr_next;
  logic [31:0] stop_addr, stop_addr_next;
  logic        done, done_next;
  logic [3:0]  rcnt;
  logic        rec;
  logic        out_free;
  logic        load;
  logic        is_rep;
  logic [31:0] adv_addr;
  result_t     result_next;

  assign out_free = !result_valid || result_ready;
  assign load     = head_valid && out_free;
  assign is_rep   = head.op == OP_REPORT;
  assign pop      = load && (!is_rep || rcnt == 4'hf);
  assign adv_addr = scan_addr + (head.ext ? 32'd4 : 32'd2);

  always_comb begin
    save_off_next  = save_off;
    save_vld_next  = save_vld;
    running_next   = running;
    fp_used_next   = fp_used;
    base_next      = base;
    scan_addr_next = scan_addr;
    stop_addr_next = stop_addr;
    done_next      = done;
    rec            = 1'b0;
    if (load) begin
      case (head.op)
        OP_BEGIN: begin
          save_vld_next  = '0;
          running_next   = '0;
          fp_used_next   = 1'b0;
          base_next      = '0;
          scan_addr_next = head.start_address;
          stop_addr_next = head.limit_address;
          done_next      = head.start_address >= head.limit_address;
        end
        OP_ANALYZE: begin
          if (!done) begin
            if (head.kind == KIND_UNKNOWN) begin
              done_next = 1'b1;
            end else begin
              rec            = 1'b1;
              scan_addr_next = adv_addr;
              done_next      = adv_addr >= stop_addr;
              running_next   = running + head.delta;
              unique case (head.kind)
                KIND_SAVE: begin
                  for (int r = 0; r < NUM_REGS; r++) begin
                    if (head.mask[r]) begin
                      save_off_next[r] = running + {25'd0, head.prefix[r]};
                    end
                  end
                  save_vld_next = save_vld | head.mask;
                end
                KIND_FRAME: begin
                  fp_used_next = 1'b1;
                  base_next    = running;
                end
                default: begin
                end
              endcase
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    result_next.recognized         = rec;
    result_next.stopped            = done_next;
    result_next.next_address       = scan_addr_next;
    result_next.stack_offset       = running_next;
    result_next.uses_frame_pointer = fp_used_next;
    result_next.frame_base_offset  = base_next;
    if (is_rep) begin
      result_next.reg_index  = rcnt;
      result_next.reg_saved  = save_vld[rcnt];
      result_next.reg_offset = save_vld[rcnt] ? save_off[rcnt] : 32'd0;
      result_next.last       = rcnt == 4'hf;
    end else begin
      result_next.reg_index  = '0;
      result_next.reg_saved  = 1'b0;
      result_next.reg_offset = '0;
      result_next.last       = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      save_vld     <= '0;
      running      <= '0;
      fp_used      <= 1'b0;
      base         <= '0;
      scan_addr    <= '0;
      stop_addr    <= '0;
      done         <= 1'b1;
      rcnt         <= '0;
      result_valid <= 1'b0;
    end else begin
      save_vld  <= save_vld_next;
      running   <= running_next;
      fp_used   <= fp_used_next;
      base      <= base_next;
      scan_addr <= scan_addr_next;
      stop_addr <= stop_addr_next;
      done      <= done_next;
      if (load && is_rep) begin
        rcnt <= rcnt + 4'd1;
      end
      if (load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    save_off <= save_off_next;
    if (load) begin
      result <= result_next;
    end
  end

endmodule

/* src/prologue_stack_frame_analyzer.sv */
// A beat is held in a queue slot, then in the result register, before it shows on the
// result side. One analyze or begin beat goes out per cycle while result_ready is high;
// a report beat stays at the queue head until it has given one result per register.
// Input beats queue up to QUEUE_DEPTH deep while the result side stalls.
// Reset (rst, synchronous): queue empty, no result pending, scan stopped,
// offsets, addresses and saved-register marks cleared.
module prologue_stack_frame_analyzer import psfa_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    item_valid,
  output logic    item_ready,
  input  item_t   item,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  entry_t push_entry;
  entry_t head;
  logic   push;
  logic   full;
  logic   pop;
  logic   head_valid;

  psfa_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .full       (full),
    .push       (push),
    .entry      (push_entry)
  );

  psfa_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  psfa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

/* src/psfa_checker.sv */
`include "assert_macros.svh"

module psfa_checker import psfa_pkg::*; (
  input logic    clk,
  input logic    rst,
  input logic    item_valid,
  input logic    item_ready,
  input item_t   item,
  input logic    result_valid,
  input logic    result_ready,
  input result_t result
);

  `ASSERT_NEXT(a_result_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "result beat changed while stalled")
  `ASSERT_ALWAYS(a_reset_idle, clk, $fell(rst), !result_valid && item_ready, "not idle after reset")
  `ASSERT_NEXT(a_report_run, clk, rst, result_valid && result_ready && !result.last, result_valid && (result.reg_index == $past(result.reg_index) + 4'd1), "report sequence broken")
  `ASSERT_SAME(a_frame_base, clk, rst, result_valid && !result.uses_frame_pointer, result.frame_base_offset == 32'sd0, "frame base set without frame pointer")

endmodule

bind prologue_stack_frame_analyzer psfa_checker u_checker (.*);
